/* hw/rtl/ulpc_pkg.sv */
// Package for the URI list percent codec.
// Holds the character constants, the per-byte result type and the helper functions.
// Depends on nothing.
package ulpc_pkg;

  // Characters the codec treats specially.
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChAlphaOf = 8'h37;  // 'A' - 10
  localparam logic [7:0] HiMask    = 8'hf0;
  localparam logic [7:0] LoMask    = 8'h0f;

  // Result buffer holds at most this many bytes for one input word.
  localparam int unsigned MaxOut   = 5;
  localparam int unsigned OutIdxW  = $clog2(MaxOut + 1);

  // Register index of the direction register.
  localparam logic RegDirection = 1'b0;

  // Outcome of one pass through the unescape stage.
  typedef struct packed {
    logic [1:0]  esc;  // new escape count
    logic [7:0]  fd;   // new held digit
    logic [1:0]  n;    // number of produced bytes
    logic [23:0] b;    // produced bytes, first in the low byte, unused bytes zero
  } unesc_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - ChZero;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else begin
      v = c - ChAlphaOf;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? ({4'b0, v} + ChZero) : ({4'b0, v} + ChAlphaOf);
  endfunction

  // Bytes that pass unescaped in encode direction.
  function automatic logic passes(input logic [7:0] c);
    logic r;
    r = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    r = r || c == "-" || c == "_" || c == "." || c == "!" || c == "~" || c == "*"
          || c == 8'h27 || c == "(" || c == ")" || c == "/" || c == ":";
    return r;
  endfunction

  // Percent escape stage of the decoder for one byte.
  function automatic unesc_t unescape(input logic [1:0] esc, input logic [7:0] fd,
                                      input logic [7:0] c);
    unesc_t r;
    logic   fresh;
    r     = '0;
    r.esc = esc;
    r.fd  = fd;
    fresh = 1'b1;
    if (esc == 2'd1) begin
      if (is_hex(c)) begin
        r.fd  = c;
        r.esc = 2'd2;
        fresh = 1'b0;
      end else begin
        r.b[7:0] = ChPercent;
        r.n      = 2'd1;
        r.esc    = 2'd0;
      end
    end else if (esc == 2'd2) begin
      if (is_hex(c)) begin
        r.b[7:0] = {hex_val(fd), 4'b0} + {4'b0, hex_val(c)};
        r.n      = 2'd1;
        r.esc    = 2'd0;
        r.fd     = '0;
        fresh    = 1'b0;
      end else begin
        r.b[15:0] = {fd, ChPercent};
        r.n       = 2'd2;
        r.esc     = 2'd0;
        r.fd      = '0;
      end
    end
    if (fresh) begin
      if (c == ChPercent) begin
        r.esc = 2'd1;
      end else begin
        r.b = r.b | ({16'b0, c} << {r.n, 3'b000});
        r.n = r.n + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/uri_list_percent_codec.sv */
// Top level of the URI list percent codec: input logic, result buffer, APB register.
// Depends on ulpc_pkg.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid_i/in_stall_o | data_byte_i, end_of_stream_i
//   out     | source    | out_valid_o/out_stall_i | out_byte_o, run_last_o
//   cfg     | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
// An accepted word is translated in the cycle it is taken and its zero to four
// result bytes land in a result buffer; the buffer then sends one byte per cycle
// while the output does not stall, through the single output port; a new word is
// taken in the cycle the last byte of the previous one leaves. Reset clears the
// direction register and the codec state and empties the buffer. A stall on the
// output holds the current byte and the input stalls.
module uri_list_percent_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ulpc_pkg::*;

  logic                 dir_q;
  logic                 lht_q, lht_d;
  logic                 cr_q, cr_d;
  logic [1:0]           esc_q, esc_d;
  logic [7:0]           fd_q, fd_d;
  logic [8*MaxOut-1:0]  obuf_q;
  logic [OutIdxW-1:0]   ocnt_q, oidx_q;
  logic [63:0]          res;
  logic [3:0]           rcnt;
  logic                 in_acc, out_take, out_last, busy, cfg_wr;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegDirection);
  assign prdata = (paddr[2] == RegDirection) ? {31'b0, dir_q} : 32'b0;

  // Handshakes.
  assign busy        = (ocnt_q != '0);
  assign out_valid_o = busy;
  assign out_last    = ({1'b0, oidx_q} + 1'b1) == {1'b0, ocnt_q};
  assign out_take    = busy && !out_stall_i;
  assign in_stall_o  = busy && !(out_take && out_last);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_byte_o  = obuf_q[{oidx_q, 3'b000} +: 8];
  assign run_last_o  = out_last;

  // Translation of one word against the current state.
  always_comb begin
    unesc_t u;
    logic   done;
    res   = '0;
    rcnt  = '0;
    lht_d = lht_q;
    cr_d  = cr_q;
    esc_d = esc_q;
    fd_d  = fd_q;
    done  = 1'b0;
    u     = '0;
    if (!dir_q) begin
      // Encode direction.
      if (data_byte_i == ChLf) begin
        if (lht_q) begin
          res[15:0] = {ChLf, ChCr};
          rcnt      = 4'd2;
          lht_d     = 1'b0;
        end
      end else if (data_byte_i != ChCr) begin
        if (passes(data_byte_i)) begin
          res[7:0] = data_byte_i;
          rcnt     = 4'd1;
        end else begin
          res[23:0] = {hex_char(data_byte_i[3:0] & LoMask[3:0]),
                       hex_char(data_byte_i[7:4] & HiMask[7:4]), ChPercent};
          rcnt      = 4'd3;
        end
        lht_d = 1'b1;
      end
    end else begin
      // Decode direction: CR LF folding, then percent escapes.
      if (cr_q) begin
        cr_d = 1'b0;
        if (data_byte_i == ChLf) begin
          u    = unescape(esc_d, fd_d, ChLf);
          done = 1'b1;
        end else begin
          u = unescape(esc_d, fd_d, ChCr);
        end
        res   = res | ({40'b0, u.b} << {rcnt, 3'b000});
        rcnt  = rcnt + {2'b0, u.n};
        esc_d = u.esc;
        fd_d  = u.fd;
      end
      if (!done) begin
        if (data_byte_i == ChCr) begin
          cr_d = 1'b1;
        end else begin
          u     = unescape(esc_d, fd_d, data_byte_i);
          res   = res | ({40'b0, u.b} << {rcnt, 3'b000});
          rcnt  = rcnt + {2'b0, u.n};
          esc_d = u.esc;
          fd_d  = u.fd;
        end
      end
      // End of stream flushes the held CR and any cut-off escape.
      if (end_of_stream_i) begin
        if (cr_d) begin
          u     = unescape(esc_d, fd_d, ChCr);
          res   = res | ({40'b0, u.b} << {rcnt, 3'b000});
          rcnt  = rcnt + {2'b0, u.n};
          esc_d = u.esc;
          fd_d  = u.fd;
        end
        if (esc_d == 2'd1) begin
          res  = res | ({56'b0, ChPercent} << {rcnt, 3'b000});
          rcnt = rcnt + 4'd1;
        end else if (esc_d == 2'd2) begin
          res  = res | ({48'b0, fd_d, ChPercent} << {rcnt, 3'b000});
          rcnt = rcnt + 4'd2;
        end
      end
    end
    if (end_of_stream_i) begin
      lht_d = 1'b0;
      cr_d  = 1'b0;
      esc_d = '0;
      fd_d  = '0;
    end
  end

  // Direction register and codec state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      lht_q <= 1'b0;
      cr_q  <= 1'b0;
      esc_q <= '0;
      fd_q  <= '0;
    end else if (cfg_wr) begin
      dir_q <= pwdata[0];
      lht_q <= 1'b0;
      cr_q  <= 1'b0;
      esc_q <= '0;
      fd_q  <= '0;
    end else if (in_acc) begin
      lht_q <= lht_d;
      cr_q  <= cr_d;
      esc_q <= esc_d;
      fd_q  <= fd_d;
    end
  end

  // Result buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      oidx_q <= '0;
    end else if (in_acc) begin
      ocnt_q <= rcnt[OutIdxW-1:0];
      oidx_q <= '0;
    end else if (out_take) begin
      if (out_last) begin
        ocnt_q <= '0;
        oidx_q <= '0;
      end else begin
        oidx_q <= oidx_q + 1'b1;
      end
    end
  end

  // Result bytes.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      obuf_q <= res[8*MaxOut-1:0];
    end
  end

endmodule
